[rtl/pkwrl_pkg.sv]
package pkwrl_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned KeyBits      = 16;
  localparam int unsigned TimeBits     = 32;
  localparam int unsigned WindowBits   = 32;
  localparam int unsigned HitBits      = 16;
  localparam int unsigned CfgDataBits  = 32;

  localparam logic [WindowBits-1:0] ResetWindow = WindowBits'(300);
  localparam logic [HitBits-1:0]    ResetHits   = HitBits'(5);

  // configuration register indexes
  localparam logic CfgWindow = 1'b0;
  localparam logic CfgHits   = 1'b1;

  typedef struct packed {
    logic [15:0] source_key;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic allowed;
    logic untracked;
  } res_t;

  // request broadcast to every cell during the lookup cycle
  typedef struct packed {
    logic                  go;
    logic                  hit_any;
    logic [KeyBits-1:0]    key;
    logic [TimeBits-1:0]   now;
    logic [WindowBits-1:0] window;
    logic [HitBits-1:0]    limit;
  } cell_bus_t;

  // status rippled from cell to cell
  typedef struct packed {
    logic hit;
    logic free;
    logic refuse;
  } chain_t;

endpackage

[rtl/pkwrl_cell.sv]
module pkwrl_cell import pkwrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_bus_t bus_i,
  input  chain_t    chain_i,
  output chain_t    chain_o,
  output logic      hit_o
);

  logic                valid_q, valid_d;
  logic [KeyBits-1:0]  key_q, key_d;
  logic [TimeBits-1:0] start_q, start_d;
  logic [HitBits-1:0]  count_q, count_d;

  logic match, passed, over, take;

  assign match  = valid_q && (key_q == bus_i.key);
  // now > start + window without wrap
  assign passed = (bus_i.now > start_q) &&
                  ((bus_i.now - start_q) > TimeBits'(bus_i.window));
  assign over   = count_q >= bus_i.limit;
  // lowest free entry takes a new key
  assign take   = !valid_q && !chain_i.free && !bus_i.hit_any;

  assign hit_o          = match;
  assign chain_o.hit    = chain_i.hit | match;
  assign chain_o.free   = chain_i.free | !valid_q;
  assign chain_o.refuse = chain_i.refuse | (match && !passed && over);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    start_d = start_q;
    count_d = count_q;
    if (bus_i.go) begin
      if (match) begin
        if (passed) begin
          start_d = bus_i.now;
          count_d = HitBits'(1);
        end else if (!over) begin
          count_d = count_q + HitBits'(1);
        end
      end else if (take) begin
        valid_d = 1'b1;
        key_d   = bus_i.key;
        start_d = bus_i.now;
        count_d = HitBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    start_q <= start_d;
    count_q <= count_d;
  end

endmodule

[rtl/per_key_window_rate_limiter_top.sv]
// Per-key fixed-window rate limiter. Each word on req_i (source key, current
// time) is taken when start_i is high and busy_o is low, and gives exactly one
// result word on res_o, shown for one cycle with done_o high and registered
// from the lookup cycle; the receiver cannot stall it, so capture res_o
// whenever done_o is high. busy_o is high for the one lookup cycle, so a new
// request can be taken as soon as it ends, also in the cycle showing a result. The
// lookup is made by the row of table cells: every cell checks its own entry
// against the request in the lookup cycle, hit, free and refuse marks ripple
// through the row, and the matching or first free cell updates itself at the
// end of that cycle. Table valid marks clear at reset; nothing else needs a
// clearing pass. Write window_seconds (index 0) and max_hits (index 1) only
// while the block is idle; max_hits of zero acts as one.
module per_key_window_rate_limiter_top import pkwrl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  req_t                   req_i,
  output logic                   done_o,
  output res_t                   res_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  // configuration registers
  logic [WindowBits-1:0] window_q;
  logic [HitBits-1:0]    hits_q;

  // request and control
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [KeyBits-1:0]  key_q;
  logic [TimeBits-1:0] now_q;
  res_t                res_q, res_d;

  logic      accept;
  cell_bus_t bus;
  chain_t    chain [TableEntries+1];
  logic [TableEntries-1:0] hit_vec;

  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= ResetWindow;
      hits_q   <= ResetHits;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWindow: window_q <= cfg_data_i[WindowBits-1:0];
        CfgHits:   hits_q   <= cfg_data_i[HitBits-1:0];
        default: ;
      endcase
    end
  end

  // latch the request word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= req_i.source_key[KeyBits-1:0];
      now_q <= req_i.now_time[TimeBits-1:0];
    end
  end

  // broadcast to the row
  assign bus.go      = busy_q;
  assign bus.hit_any = chain[TableEntries].hit;
  assign bus.key     = key_q;
  assign bus.now     = now_q;
  assign bus.window  = window_q;
  assign bus.limit   = (hits_q == '0) ? HitBits'(1) : hits_q;

  assign chain[0] = '0;

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    pkwrl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bus_i   (bus),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .hit_o   (hit_vec[i])
    );
  end

  // result from the end of the row
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    res_d  = res_q;
    if (busy_q) begin
      busy_d          = 1'b0;
      done_d          = 1'b1;
      res_d.allowed   = !chain[TableEntries].refuse;
      // new key, no free entry: pass it unrecorded
      res_d.untracked = !chain[TableEntries].hit && !chain[TableEntries].free;
    end else if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  // a key sits in at most one entry
  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(hit_vec) <= 1)
    else $error("key found in more than one entry");

  // a result follows exactly one lookup cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o && !busy_o)
    else $error("lookup did not produce a result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result without lookup");

  // an untracked request is always passed
  a_untracked_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.untracked |-> res_o.allowed)
    else $error("untracked request refused");

endmodule
